/* rtl/fra_pkg.sv */
// Package for the free room allocator: field widths, word types and control states.
package fra_pkg;

  // Field widths of the event and result words.
  localparam int ROOM_W   = 10;
  localparam int CNT_W    = 11;
  localparam int MEET_W   = 10;
  localparam int MEETINGS = 1 << MEET_W;

  // Default number of rooms.
  localparam int ROOMS_DEF = 1024;

  // Event kinds.
  localparam logic OP_FINISH = 1'b0;
  localparam logic OP_START  = 1'b1;

  // Status codes.
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_ROOM = 1'b1;

  typedef struct packed {
    logic              op;
    logic [MEET_W-1:0] meeting_id;
  } fra_in_t;

  typedef struct packed {
    logic [ROOM_W-1:0] room;
    logic [CNT_W-1:0]  rooms_in_use;
    logic [CNT_W-1:0]  peak_rooms;
    logic              status;
  } fra_out_t;

  typedef enum logic {
    FRA_IDLE,
    FRA_EXEC
  } fra_state_t;

endpackage

/* rtl/fra_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module fra_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/free_room_allocator.sv */
// Top level of the free room allocator: room stack, meeting table and counters.
//
// Usage: events arrive in time order on in_word (op: 1 start, 0 finish, and the
// meeting id). An event word is taken at a rising edge where start is high and
// busy is low. A start pops the top free room and records it for the meeting; a
// finish pushes the meeting's recorded room back onto the free stack.
// Every event gives one result word on out_word, marked by out_valid for one
// cycle, in the cycle right after the work cycle: the word is registered at the
// edge that ends the work cycle.
// The receiver cannot stall, so the result must be captured in that cycle.
// A new event is taken only while busy is low: the stack memory and the meeting
// table are read at the accepting edge, and the work cycle that follows
// updates the counters and writes back; busy is high then.
// After reset the stack holds every room, room 0 on top, and no room is in use.
// Stack entries below the lowest fill level reached are never read from the
// memory; their reset contents are derived from the index, so no clearing pass
// is needed and events are accepted right after reset.
module free_room_allocator #(
  parameter int ROOMS = fra_pkg::ROOMS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fra_pkg::fra_in_t in_word,
  output logic             out_valid,
  output fra_pkg::fra_out_t out_word
);

  import fra_pkg::*;

  localparam int RW = $clog2(ROOMS);
  localparam int CW = $clog2(ROOMS + 1);
  localparam logic [CW-1:0] ROOMS_C = CW'(ROOMS);

  // Control and counters.
  fra_state_t        state_r, state_nxt;
  logic              op_r;
  logic [MEET_W-1:0] id_r;
  logic [CW-1:0]     count_r, count_nxt;   // free rooms on the stack
  logic [CW-1:0]     low_r, low_nxt;       // lowest fill level reached
  logic [CW-1:0]     peak_r, peak_nxt;
  logic              out_valid_r, out_valid_nxt;
  fra_out_t          out_r, out_nxt;

  // Memory ports.
  logic [RW-1:0] stk_rdata, meet_rdata;
  logic          stk_we, meet_we;
  logic [RW-1:0] room;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] used_after;
  logic          accept;

  assign accept = start && (state_r == FRA_IDLE);
  assign busy   = (state_r == FRA_EXEC);
  assign cnt_m1 = count_r - CW'(1);

  fra_ram #(.WIDTH(RW), .DEPTH(ROOMS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (count_r[RW-1:0]),
    .wdata (room),
    .raddr (cnt_m1[RW-1:0]),
    .rdata (stk_rdata)
  );

  fra_ram #(.WIDTH(RW), .DEPTH(MEETINGS)) u_meet (
    .clk   (clk),
    .we    (meet_we),
    .waddr (id_r),
    .wdata (room),
    .raddr (in_word.meeting_id),
    .rdata (meet_rdata)
  );

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FRA_IDLE;
      count_r     <= ROOMS_C;
      low_r       <= ROOMS_C;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      low_r       <= low_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_word.op;
      id_r <= in_word.meeting_id;
    end
    out_r <= out_nxt;
  end

  // Next state, stack update and result word.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    low_nxt       = low_r;
    peak_nxt      = peak_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    stk_we        = 1'b0;
    meet_we       = 1'b0;
    room          = '0;
    used_after    = ROOMS_C - cnt_m1;

    case (state_r)
      FRA_IDLE: begin
        if (accept) begin
          state_nxt = FRA_EXEC;
        end
      end
      FRA_EXEC: begin
        state_nxt     = FRA_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt.status = ST_OK;
        if (op_r == OP_START) begin
          if (count_r == '0) begin
            out_nxt.status = ST_NO_ROOM;
          end else begin
            // Entries below the lowest level reached still hold their reset room.
            if (cnt_m1 >= low_r) begin
              room = stk_rdata;
            end else begin
              room = RW'((ROOMS_C - CW'(1)) - cnt_m1);
            end
            meet_we   = 1'b1;
            count_nxt = cnt_m1;
            if (cnt_m1 < low_r) begin
              low_nxt = cnt_m1;
            end
            if (used_after > peak_r) begin
              peak_nxt = used_after;
            end
          end
        end else begin
          room = meet_rdata;
          if (count_r < ROOMS_C) begin
            stk_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        out_nxt.room         = ROOM_W'(room);
        out_nxt.rooms_in_use = CNT_W'(ROOMS_C - count_nxt);
        out_nxt.peak_rooms   = CNT_W'(peak_nxt);
      end
      default: begin
        state_nxt = FRA_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef ASSERT_OFF
  // The work cycle always returns to idle.
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FRA_EXEC |=> state_r == FRA_IDLE)
    else $error("allocator stayed busy");

  // A result word follows a work cycle and nothing else.
  a_valid_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == FRA_EXEC))
    else $error("result word without an event");

  // The free count never exceeds the number of rooms.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ROOMS_C)
    else $error("free count out of range");

  // The low water mark never lies above the fill level.
  a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= count_r)
    else $error("low water mark above fill level");
`endif

endmodule
